>>> sv/sps_pkg.sv
package sps_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned POS_W      = 32;
    localparam int unsigned COIL_W     = 4;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_DATA_W   = 96;
    localparam int unsigned M_DATA_W   = 40;

    localparam logic [TIME_W-1:0] STEP_INTERVAL_RESET = 32'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE     = 8'd1;

    typedef enum logic [MODE_W-1:0] {
        CMD_TICK          = 3'd0,
        CMD_MOVE_ABS      = 3'd1,
        CMD_MOVE_REL      = 3'd2,
        CMD_LOCAL_STOP    = 3'd3,
        CMD_DISABLE       = 3'd4,
        CMD_GLOBAL_STOP   = 3'd5,
        CMD_GLOBAL_RESUME = 3'd6
    } cmd_e_t;

    typedef struct packed {
        cmd_e_t                   mode;
        logic [TIME_W-1:0]        now_time;
        logic signed [POS_W-1:0]  target_value;
        logic signed [POS_W-1:0]  step_delta;
    } cmd_t;

    typedef struct packed {
        logic [TIME_W-1:0] step_interval;
        logic              step_mode;
    } cfg_t;

    typedef struct packed {
        logic                    halted;
        logic                    stepped;
        logic                    moving;
        logic signed [POS_W-1:0] current_position;
        logic [COIL_W-1:0]       coil_pattern;
    } result_t;

    function automatic logic [COIL_W-1:0] full_step_coils(input logic [1:0] idx);
        logic [COIL_W-1:0] c;
        unique case (idx)
            2'd0: c = 4'hA;
            2'd1: c = 4'h9;
            2'd2: c = 4'h5;
            2'd3: c = 4'h6;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

    function automatic logic [COIL_W-1:0] half_step_coils(input logic [2:0] idx);
        logic [COIL_W-1:0] c;
        unique case (idx)
            3'd0: c = 4'h8;
            3'd1: c = 4'hA;
            3'd2: c = 4'h2;
            3'd3: c = 4'h6;
            3'd4: c = 4'h4;
            3'd5: c = 4'h5;
            3'd6: c = 4'h1;
            3'd7: c = 4'h9;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

>>> sv/sps_core.sv
module sps_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  sps_pkg::cmd_t     cmd,
    input  sps_pkg::cfg_t     cfg,
    output sps_pkg::result_t  res_next
);
    import sps_pkg::*;

    logic signed [POS_W-1:0] position_reg, position_next;
    logic signed [POS_W-1:0] target_reg, target_next;
    logic [TIME_W-1:0]       last_step_time_reg, last_step_time_next;
    logic                    enabled_reg, enabled_next;
    logic                    local_stop_reg, local_stop_next;
    logic                    global_stop_reg, global_stop_next;
    logic [COIL_W-1:0]       coil_drive_reg, coil_drive_next;

    logic signed [POS_W:0]   rel_sum;
    logic signed [POS_W-1:0] rel_target;
    logic signed [POS_W-1:0] stepped_pos;
    logic [TIME_W-1:0]       elapsed;
    logic                    tick_active;
    logic                    step_now;

    always_comb begin
        rel_sum = {position_reg[POS_W-1], position_reg}
                + {cmd.step_delta[POS_W-1], cmd.step_delta};
        if (rel_sum[POS_W] != rel_sum[POS_W-1]) begin
            rel_target = rel_sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                        : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            rel_target = rel_sum[POS_W-1:0];
        end
    end

    assign elapsed     = cmd.now_time - last_step_time_reg;
    assign tick_active = enabled_reg && !local_stop_reg && !global_stop_reg;
    assign step_now    = tick_active && (position_reg != target_reg)
                         && (elapsed >= cfg.step_interval);
    assign stepped_pos = (target_reg > position_reg) ? position_reg + 32'sd1
                                                     : position_reg - 32'sd1;

    always_comb begin
        position_next       = position_reg;
        target_next         = target_reg;
        last_step_time_next = last_step_time_reg;
        enabled_next        = enabled_reg;
        local_stop_next     = local_stop_reg;
        global_stop_next    = global_stop_reg;
        coil_drive_next     = coil_drive_reg;
        unique case (cmd.mode)
            CMD_TICK: begin
                if (tick_active && (position_reg == target_reg)) begin
                    enabled_next = 1'b0;
                end else if (step_now) begin
                    last_step_time_next = cmd.now_time;
                    position_next       = stepped_pos;
                    coil_drive_next     = cfg.step_mode ? half_step_coils(stepped_pos[2:0])
                                                        : full_step_coils(stepped_pos[1:0]);
                end
            end
            CMD_MOVE_ABS: begin
                target_next  = cmd.target_value;
                enabled_next = 1'b1;
            end
            CMD_MOVE_REL: begin
                target_next  = rel_target;
                enabled_next = 1'b1;
            end
            CMD_LOCAL_STOP: begin
                local_stop_next = 1'b1;
                enabled_next    = 1'b0;
            end
            CMD_DISABLE:       enabled_next     = 1'b0;
            CMD_GLOBAL_STOP:   global_stop_next = 1'b1;
            CMD_GLOBAL_RESUME: global_stop_next = 1'b0;
            default: begin
            end
        endcase
    end

    always_comb begin
        res_next.coil_pattern     = coil_drive_next;
        res_next.current_position = position_next;
        res_next.moving           = enabled_next && (position_next != target_next);
        res_next.stepped          = (cmd.mode == CMD_TICK) && step_now;
        res_next.halted           = local_stop_next || global_stop_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg       <= '0;
            target_reg         <= '0;
            last_step_time_reg <= '0;
            enabled_reg        <= 1'b0;
            local_stop_reg     <= 1'b0;
            global_stop_reg    <= 1'b0;
            coil_drive_reg     <= '0;
        end else if (fire) begin
            position_reg       <= position_next;
            target_reg         <= target_next;
            last_step_time_reg <= last_step_time_next;
            enabled_reg        <= enabled_next;
            local_stop_reg     <= local_stop_next;
            global_stop_reg    <= global_stop_next;
            coil_drive_reg     <= coil_drive_next;
        end
    end

endmodule

>>> sv/stepper_position_sequencer.sv
// Stepper position sequencer.
// The s_ channel carries one command per transaction: s_tuser is the command
// (tick, move absolute, move relative, local stop, disable, global stop,
// global resume) and s_tdata holds the time, absolute target and relative
// step count. Every command yields exactly one m_ transaction reporting coil
// drive, position and the moving, stepped and halted flags after it.
// The cfg channel writes step_interval (index 0) and step_mode (index 1);
// other indexes are dropped. Write it only while the block is idle.
// An accepted command is held in the input register; the state update turns it
// into a result, which is registered in the result register that drives m_tvalid.
// The block takes one command per cycle while the m_ side takes results.
// A stalled m_ side holds the result; the input register still takes one more
// command, after which s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) clears position, target, step time,
// enable, both stops and the coils, empties both registers and restores
// step_interval to 10000 and full-step mode.
module stepper_position_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_time[31:0], target_value[63:32], step_delta[95:64]
    input  logic [sps_pkg::S_DATA_W-1:0]    s_tdata,
    // mode[2:0]
    input  logic [sps_pkg::MODE_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // coil_pattern[3:0], current_position[35:4], moving[36], stepped[37],
    // halted[38], zero[39]
    output logic [sps_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sps_pkg::*;

    logic    in_valid_reg;
    cmd_t    in_cmd_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t res_next;
    cfg_t    cfg_reg;
    logic    s_fire;
    logic    advance;
    logic    fire;

    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval <= STEP_INTERVAL_RESET;
            cfg_reg.step_mode     <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_STEP_INTERVAL) begin
                cfg_reg.step_interval <= cfg_data;
            end else if (cfg_index == CFG_STEP_MODE) begin
                cfg_reg.step_mode <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg.mode         <= cmd_e_t'(s_tuser);
            in_cmd_reg.now_time     <= s_tdata[31:0];
            in_cmd_reg.target_value <= s_tdata[63:32];
            in_cmd_reg.step_delta   <= s_tdata[95:64];
        end
    end

    sps_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .cmd      (in_cmd_reg),
        .cfg      (cfg_reg),
        .res_next (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with result register empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.stepped) |-> (out_res_reg.coil_pattern != '0))
        else $error("step reported with coils off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.stepped) |-> !out_res_reg.halted)
        else $error("step reported while halted");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed command lost its result");

endmodule

>>> tb/sv/stepper_position_sequencer_tb.sv
`timescale 1ns / 1ps

module stepper_position_sequencer_tb;

    import sps_pkg::*;

    localparam logic [MODE_W-1:0]    CMD_UNUSED     = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_SUCH    = 8'hFF;
    localparam logic [15:0]          FULL_STEP_SEQ  = 16'h659A;
    localparam logic [31:0]          HALF_STEP_SEQ  = 32'h915462A8;
    localparam int                   HOLD_CYCLES    = 300;
    localparam int                   CYCLE_LIMIT    = 400000;
    localparam int                   PHASE_ITEMS    = 270;
    localparam logic signed [31:0]   POS_MAX        = 32'sh7FFFFFFF;
    localparam logic signed [31:0]   POS_MIN        = 32'sh80000000;

    class position_tracker;
        logic [31:0]        interval;
        logic               half_mode;
        logic signed [31:0] position;
        logic signed [31:0] target;
        logic [31:0]        last_step;
        bit                 enabled;
        bit                 local_stop;
        bit                 global_stop;
        logic [3:0]         coils;
        result_t            pending_results[$];
        int                 errors;

        function new();
            interval    = STEP_INTERVAL_RESET;
            half_mode   = 1'b0;
            position    = '0;
            target      = '0;
            last_step   = '0;
            enabled     = 1'b0;
            local_stop  = 1'b0;
            global_stop = 1'b0;
            coils       = '0;
            errors      = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == CFG_STEP_INTERVAL) begin
                interval = value;
            end else if (idx == CFG_STEP_MODE) begin
                half_mode = value[0];
            end
        endfunction

        function void note_command(logic [MODE_W-1:0] mode, logic [31:0] now_t,
                                   logic signed [31:0] tval, logic signed [31:0] delta);
            result_t     r;
            bit          stepped;
            longint      sum;
            logic [31:0] elapsed;
            stepped = 1'b0;
            case (mode)
                CMD_TICK: begin
                    if (enabled && !local_stop && !global_stop) begin
                        elapsed = now_t - last_step;
                        if (position == target) begin
                            enabled = 1'b0;
                        end else if (elapsed >= interval) begin
                            last_step = now_t;
                            position  = (target > position) ? position + 1 : position - 1;
                            coils     = half_mode ? HALF_STEP_SEQ[position[2:0]*4 +: 4]
                                                  : FULL_STEP_SEQ[position[1:0]*4 +: 4];
                            stepped   = 1'b1;
                        end
                    end
                end
                CMD_MOVE_ABS: begin
                    target  = tval;
                    enabled = 1'b1;
                end
                CMD_MOVE_REL: begin
                    sum = longint'(position) + longint'(delta);
                    if (sum > longint'(POS_MAX)) sum = longint'(POS_MAX);
                    if (sum < longint'(POS_MIN)) sum = longint'(POS_MIN);
                    target  = sum[31:0];
                    enabled = 1'b1;
                end
                CMD_LOCAL_STOP: begin
                    local_stop = 1'b1;
                    enabled    = 1'b0;
                end
                CMD_DISABLE:       enabled = 1'b0;
                CMD_GLOBAL_STOP:   global_stop = 1'b1;
                CMD_GLOBAL_RESUME: global_stop = 1'b0;
                default: ;
            endcase
            r.coil_pattern     = coils;
            r.current_position = position;
            r.moving           = enabled && (position != target);
            r.stepped          = stepped;
            r.halted           = local_stop || global_stop;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data);
            result_t want;
            result_t got;
            if (pending_results.size() == 0) begin
                $error("result transaction with no command outstanding: %h", data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            got  = result_t'(data[$bits(result_t)-1:0]);
            if (got.coil_pattern !== want.coil_pattern) begin
                $error("coil_pattern: expected %h, got %h", want.coil_pattern, got.coil_pattern);
                errors++;
            end
            if (got.current_position !== want.current_position) begin
                $error("current_position: expected %0d, got %0d",
                       want.current_position, got.current_position);
                errors++;
            end
            if (got.moving !== want.moving) begin
                $error("moving: expected %b, got %b", want.moving, got.moving);
                errors++;
            end
            if (got.stepped !== want.stepped) begin
                $error("stepped: expected %b, got %b", want.stepped, got.stepped);
                errors++;
            end
            if (got.halted !== want.halted) begin
                $error("halted: expected %b, got %b", want.halted, got.halted);
                errors++;
            end
            if (data[M_DATA_W-1:$bits(result_t)] !== '0) begin
                $error("pad: expected 0, got %b", data[M_DATA_W-1:$bits(result_t)]);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [MODE_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    position_tracker trk = new();
    int              cycles = 0;
    int              burst_left = 1;
    bit              hold_req = 1'b0;

    stepper_position_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            trk.check_result(m_tdata);
        end
    end

    // receiver: changing stall pattern, plus one long hold-off on request
    initial begin
        int style;
        int span;
        int tick_ctr;
        style    = 0;
        span     = 0;
        tick_ctr = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++) @(negedge aclk);
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 300);
            end
            span--;
            tick_ctr++;
            case (style)
                0:       m_tready = 1'b1;
                1:       m_tready = 1'($urandom_range(0, 1));
                2:       m_tready = (tick_ctr % 4 == 0);
                default: m_tready = (tick_ctr % 2 == 0);
            endcase
        end
    end

    task automatic push_command(input logic [MODE_W-1:0] mode, input logic [31:0] now_t,
                                input logic [31:0] tval, input logic [31:0] delta);
        int gap;
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {delta, tval, now_t};
        do @(posedge aclk); while (!s_tready);
        trk.note_command(mode, now_t, tval, delta);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        trk.set_register(idx, value);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // drop valid and hold until every result is back and the pipeline is empty
    task automatic settle();
        s_tvalid = 1'b0;
        while (trk.outstanding() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_tick_time();
        logic [31:0] offset;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: offset = trk.interval + $urandom_range(0, 3);
            6:                offset = trk.interval - 1;
            7:                offset = $urandom_range(0, trk.interval);
            8:                offset = $urandom;
            default:          offset = '0;
        endcase
        return trk.last_step + offset;
    endfunction

    task automatic issue_random(input bit allow_local);
        logic [MODE_W-1:0] mode;
        logic [31:0]       now_t;
        logic [31:0]       tval;
        logic [31:0]       delta;
        int                pick;
        now_t = $urandom;
        tval  = $urandom;
        delta = $urandom;
        pick  = $urandom_range(0, 99);
        if (!trk.enabled || trk.position == trk.target) begin
            if (pick < 45) begin
                mode  = CMD_MOVE_REL;
                delta = $urandom_range(1, 12);
                if ($urandom_range(0, 1)) delta = -delta;
            end else if (pick < 65) begin
                mode = CMD_MOVE_ABS;
                tval = trk.position + $urandom_range(0, 24) - 12;
            end else if (pick < 85) begin
                mode = CMD_TICK;
            end else begin
                pick = 100;
            end
        end else begin
            if (pick < 78)      mode = CMD_TICK;
            else if (pick < 81) mode = CMD_DISABLE;
            else if (pick < 85) mode = CMD_GLOBAL_STOP;
            else if (pick < 90) mode = CMD_GLOBAL_RESUME;
            else                pick = 100;
        end
        if (pick == 100) begin
            case ($urandom_range(0, 8))
                0: mode = CMD_UNUSED;
                1: mode = CMD_MOVE_ABS;
                2: begin
                    mode  = CMD_MOVE_REL;
                    delta = (trk.position >= 0) ? POS_MAX : POS_MIN;
                end
                3: mode = CMD_MOVE_REL;
                4: mode = CMD_GLOBAL_STOP;
                5: mode = CMD_GLOBAL_RESUME;
                6: mode = CMD_DISABLE;
                7: mode = allow_local ? CMD_LOCAL_STOP : CMD_UNUSED;
                default: begin
                    mode  = CMD_TICK;
                    now_t = $urandom;
                end
            endcase
        end else if (mode == CMD_TICK) begin
            now_t = pick_tick_time();
        end
        if (trk.global_stop && $urandom_range(0, 3) == 0) mode = CMD_GLOBAL_RESUME;
        push_command(mode, now_t, tval, delta);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);

        push_command(CMD_TICK, 32'd0, $urandom, $urandom);
        push_command(CMD_MOVE_ABS, $urandom, 32'd2, $urandom);
        push_command(CMD_TICK, 32'd9999, $urandom, $urandom);
        push_command(CMD_TICK, 32'd10000, $urandom, $urandom);
        push_command(CMD_TICK, 32'd20000, $urandom, $urandom);
        push_command(CMD_TICK, 32'd30000, $urandom, $urandom);
        push_command(CMD_MOVE_REL, $urandom, $urandom, -32'sd6);
        push_command(CMD_GLOBAL_STOP, $urandom, $urandom, $urandom);
        push_command(CMD_TICK, 32'd40000, $urandom, $urandom);
        push_command(CMD_GLOBAL_RESUME, $urandom, $urandom, $urandom);
        for (int i = 0; i < 7; i++) begin
            push_command(CMD_TICK, 32'd40000 + i * 10000, $urandom, $urandom);
        end
        push_command(CMD_DISABLE, $urandom, $urandom, $urandom);
        push_command(CMD_UNUSED, $urandom, $urandom, $urandom);
        push_command(CMD_MOVE_ABS, $urandom, POS_MAX, $urandom);
        push_command(CMD_MOVE_ABS, $urandom, POS_MIN, $urandom);
        push_command(CMD_MOVE_REL, $urandom, $urandom, POS_MIN);
        push_command(CMD_MOVE_REL, $urandom, $urandom, POS_MAX);
        push_command(CMD_TICK, 32'hFFFFFFFF, $urandom, $urandom);
        push_command(CMD_DISABLE, $urandom, $urandom, $urandom);

        for (int p = 0; p < 7; p++) begin
            settle();
            case (p)
                0: begin
                    write_register(CFG_STEP_INTERVAL, 32'd0);
                    write_register(CFG_STEP_MODE, 32'd1);
                end
                1: begin
                    write_register(CFG_STEP_INTERVAL, 32'hFFFFFFFF);
                    write_register(CFG_STEP_MODE, 32'd0);
                end
                2: begin
                    write_register(CFG_STEP_INTERVAL, $urandom_range(1, 50));
                    write_register(CFG_STEP_MODE, 32'hFFFFFFFF);
                    hold_req = 1'b1;
                end
                3: begin
                    write_register(CFG_STEP_INTERVAL, 32'd1);
                    write_register(CFG_STEP_MODE, 32'hFFFFFFFE);
                    write_register(CFG_NO_SUCH, $urandom);
                end
                4: begin
                    write_register(CFG_STEP_INTERVAL, $urandom_range(100, 100000));
                    write_register(CFG_STEP_MODE, 32'd1);
                end
                5: begin
                    write_register(CFG_STEP_INTERVAL, 32'd10000);
                    write_register(CFG_STEP_MODE, 32'd0);
                end
                default: begin
                    write_register(CFG_STEP_INTERVAL, 32'd3);
                    write_register(CFG_STEP_MODE, 32'd1);
                end
            endcase
            if (p < 6) begin
                repeat (PHASE_ITEMS) issue_random(1'b0);
            end else begin
                repeat (200) issue_random(1'b0);
                push_command(CMD_LOCAL_STOP, $urandom, $urandom, $urandom);
                repeat (60) issue_random(1'b1);
            end
        end

        settle();
        repeat (10) @(negedge aclk);
        if (trk.errors == 0 && trk.outstanding() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
